FILE: design/lupc_pkg.sv
// Shared types and constants for the LRAT unit propagation checker.
// No dependencies.
package lupc_pkg;

   localparam int NumVars = 4096;
   localparam int NumClauses = 16384;
   localparam int LitStore = 65536;
   localparam int VarW = $clog2(NumVars);
   localparam int IdW = 14;
   localparam int PtrW = $clog2(LitStore) + 1;
   localparam int LitW = 13;

   localparam logic [1:0] ACT_INPUT = 2'd0;
   localparam logic [1:0] ACT_LEMMA = 2'd1;
   localparam logic [1:0] ACT_HINT = 2'd2;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_VERIFIED = 3'd1;
   localparam logic [2:0] ST_INVALID = 3'd2;
   localparam logic [2:0] ST_NOT_EARLIER = 3'd3;
   localparam logic [2:0] ST_UNBOUND = 3'd4;
   localparam logic [2:0] ST_DUPLICATE = 3'd5;
   localparam logic [2:0] ST_FULL = 3'd6;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_LEMMA = 2'd1;
   localparam logic [1:0] PH_CHECK = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   typedef struct packed {
      logic [1:0] action;
      logic [LitW-1:0] literal;
      logic [IdW-1:0] clause_id;
   } item_type;

endpackage

FILE: design/lupc_front.sv
// Input stage of the checker: a two-entry item queue in front of the engine.
// Depends on lupc_pkg.
module lupc_front
   import lupc_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic push,
   output logic full,
   input item_type push_item,
   output logic has_item,
   output item_type head_item,
   input logic take
);

   item_type slot_ff [2];
   logic [1:0] count_ff, count_in;
   logic rd_ff, wr_ff;
   logic do_push;

   assign full = count_ff == 2'd2;
   assign has_item = count_ff != 2'd0;
   assign head_item = slot_ff[rd_ff];
   assign do_push = push && !full;

   // Occupancy follows pushes and takes.
   always_comb begin
      count_in = count_ff + {1'b0, do_push} - {1'b0, take && has_item};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (do_push) wr_ff <= !wr_ff;
         if (take && has_item) rd_ff <= !rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_item;
   end

   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("item queue overflow");
   assert property (@(posedge clock) disable iff (reset)
      full |=> !($past(push) && count_ff == 2'd0 && !$past(take)))
      else $error("push accepted while full");
   assert property (@(posedge clock) disable iff (reset)
      !has_item |=> count_ff <= 2'd1)
      else $error("queue grew by more than one");

endmodule

FILE: design/lupc_back.sv
// Execution engine: literal store, clause table, assignment and hint scanning.
// Depends on lupc_pkg.
module lupc_back
   import lupc_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic has_item,
   input item_type head_item,
   output logic take,
   output logic rsp_empty,
   output logic [2:0] rsp_status,
   output logic rsp_refuted,
   input logic rsp_pop
);

   // Sequencer states.
   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_WIPE = 4'd2;
   localparam logic [3:0] S_TBL = 4'd3;
   localparam logic [3:0] S_TBLW = 4'd4;
   localparam logic [3:0] S_SREAD = 4'd5;
   localparam logic [3:0] S_SWAIT = 4'd6;
   localparam logic [3:0] S_AWAIT = 4'd7;
   localparam logic [3:0] S_AEVAL = 4'd8;
   localparam logic [3:0] S_UNIT = 4'd9;
   localparam logic [3:0] S_OUT = 4'd10;
   localparam logic [3:0] S_ASET = 4'd11;

   logic [LitW-1:0] store_mem [LitStore];
   logic [PtrW-2:0] start_mem [NumClauses];
   logic [1:0] asg_mem [NumVars];

   logic [3:0] state_ff;
   logic [PtrW-1:0] wp_ff, open_ff, scan_ff;
   logic [IdW-1:0] lemma_id_ff;
   logic [1:0] phase_ff;
   logic empty_lemma_ff, refuted_ff;
   logic [IdW:0] clr_ff;
   item_type cur_ff;
   logic [PtrW-2:0] start_rd_ff;
   logic [LitW-1:0] lit_rd_ff, lit_ff, unit_ff;
   logic [1:0] asg_rd_ff;
   logic [1:0] open_cnt_ff;
   logic out_valid_ff;
   logic [2:0] out_st_ff;
   logic [2:0] st_ff;
   logic [VarW-1:0] asg_wa_ff;
   logic [1:0] asg_wd_ff;
   logic asg_we_ff;
   logic [PtrW-2:0] st_rd_addr;
   logic [VarW-1:0] asg_rd_addr;
   logic bind_ok;

   // Variable number of a signed literal and its range check.
   function automatic logic [LitW-1:0] lit_var(input logic [LitW-1:0] raw);
      lit_var = raw[LitW-1] ? (~raw + 1'b1) : raw;
   endfunction
   function automatic logic var_ok(input logic [LitW-1:0] raw);
      logic [LitW-1:0] v;
      v = lit_var(raw);
      var_ok = v < LitW'(NumVars);
   endfunction
   function automatic logic [VarW-1:0] var_index(input logic [LitW-1:0] raw);
      logic [LitW-1:0] v;
      v = lit_var(raw);
      var_index = v[VarW-1:0];
   endfunction

   assign rsp_empty = !out_valid_ff;
   assign rsp_status = out_st_ff;
   assign rsp_refuted = refuted_ff;
   assign take = state_ff == S_IDLE && has_item && !out_valid_ff;
   assign st_rd_addr = scan_ff[PtrW-2:0];
   assign asg_rd_addr = var_index(lit_rd_ff);

   // A clause binds only when its id is free and the terminator fits.
   assign bind_ok = state_ff == S_TBLW && st_ff == ST_OK && start_rd_ff == '0 &&
                    !wp_ff[PtrW-1];

   // Memories: store, clause table and assignment written and read in one clocked block.
   always_ff @(posedge clock) begin
      lit_rd_ff <= store_mem[st_rd_addr];
      start_rd_ff <= start_mem[cur_ff.clause_id];
      asg_rd_ff <= asg_mem[asg_rd_addr];
      if (asg_we_ff) asg_mem[asg_wa_ff] <= asg_wd_ff;
      if (state_ff == S_CLEAR)
         start_mem[clr_ff[IdW-1:0]] <= '0;
      else if (bind_ok)
         start_mem[cur_ff.clause_id] <= open_ff[PtrW-2:0];
      if (bind_ok)
         store_mem[wp_ff[PtrW-2:0]] <= '0;
      else if (state_ff == S_ASET && cur_ff.literal != '0 && !wp_ff[PtrW-1])
         store_mem[wp_ff[PtrW-2:0]] <= cur_ff.literal;
   end

   // Main sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         wp_ff <= PtrW'(1);
         open_ff <= PtrW'(1);
         lemma_id_ff <= '0;
         phase_ff <= PH_IDLE;
         empty_lemma_ff <= 1'b0;
         refuted_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         asg_we_ff <= 1'b1;
         asg_wa_ff <= '0;
         asg_wd_ff <= '0;
      end else begin
         asg_we_ff <= 1'b0;
         if (rsp_pop && out_valid_ff) out_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               // Clear clause table and assignment after reset.
               if (clr_ff < (IdW+1)'(NumVars)) begin
                  asg_we_ff <= 1'b1;
                  asg_wa_ff <= clr_ff[VarW-1:0];
                  asg_wd_ff <= '0;
               end
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (IdW+1)'(NumClauses - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (take) begin
                  cur_ff <= head_item;
                  st_ff <= ST_OK;
                  state_ff <= S_OUT;
                  if (head_item.action == ACT_INPUT) begin
                     if (phase_ff == PH_LEMMA) begin
                        wp_ff <= open_ff;
                        phase_ff <= PH_IDLE;
                     end
                     state_ff <= head_item.literal != '0 ? S_ASET : S_TBL;
                  end else if (head_item.action == ACT_LEMMA) begin
                     if (phase_ff != PH_LEMMA) begin
                        wp_ff <= open_ff;
                        empty_lemma_ff <= 1'b1;
                        phase_ff <= PH_LEMMA;
                        clr_ff <= '0;
                        state_ff <= S_WIPE;
                     end else begin
                        state_ff <= head_item.literal != '0 ? S_ASET : S_TBL;
                     end
                  end else if (head_item.action == ACT_HINT) begin
                     if (phase_ff == PH_IDLE || phase_ff == PH_LEMMA) begin
                        st_ff <= ST_INVALID;
                     end else if (phase_ff == PH_CHECK) begin
                        if (head_item.clause_id == '0) begin
                           st_ff <= ST_INVALID;
                           phase_ff <= PH_DONE;
                        end else if (head_item.clause_id >= lemma_id_ff) begin
                           st_ff <= ST_NOT_EARLIER;
                           phase_ff <= PH_DONE;
                        end else begin
                           state_ff <= S_SREAD;
                        end
                     end
                  end
               end
            end
            S_WIPE: begin
               asg_we_ff <= 1'b1;
               asg_wa_ff <= clr_ff[VarW-1:0];
               asg_wd_ff <= '0;
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (IdW+1)'(NumVars - 1))
                  state_ff <= cur_ff.literal != '0 ? S_ASET : S_TBL;
            end
            S_ASET: begin
               // Append a literal; lemma literals assign their negation.
               if (wp_ff[PtrW-1]) st_ff <= ST_FULL;
               else wp_ff <= wp_ff + 1'b1;
               if (cur_ff.action == ACT_LEMMA) begin
                  empty_lemma_ff <= 1'b0;
                  if (var_ok(cur_ff.literal)) begin
                     asg_we_ff <= 1'b1;
                     asg_wa_ff <= var_index(cur_ff.literal);
                     asg_wd_ff <= cur_ff.literal[LitW-1] ? 2'd1 : 2'd2;
                  end
               end
               state_ff <= S_OUT;
            end
            S_TBL: begin
               // Clause table read is in flight.
               state_ff <= S_TBLW;
               if (cur_ff.clause_id == '0) st_ff <= ST_UNBOUND;
            end
            S_TBLW: begin
               if (st_ff == ST_OK && start_rd_ff != '0) st_ff <= ST_DUPLICATE;
               else if (st_ff == ST_OK && wp_ff[PtrW-1]) st_ff <= ST_FULL;
               if (st_ff == ST_OK && start_rd_ff == '0 && !wp_ff[PtrW-1]) begin
                  wp_ff <= wp_ff + 1'b1;
                  open_ff <= wp_ff + 1'b1;
                  if (cur_ff.action == ACT_LEMMA) begin
                     lemma_id_ff <= cur_ff.clause_id;
                     phase_ff <= PH_CHECK;
                  end
               end else begin
                  wp_ff <= open_ff;
                  if (cur_ff.action == ACT_LEMMA) phase_ff <= PH_DONE;
               end
               state_ff <= S_OUT;
            end
            S_SREAD: begin
               state_ff <= S_SWAIT;
               open_cnt_ff <= '0;
            end
            S_SWAIT: begin
               // Start of the hint clause is known now.
               if (start_rd_ff == '0) begin
                  st_ff <= ST_UNBOUND;
                  phase_ff <= PH_DONE;
                  state_ff <= S_OUT;
               end else begin
                  scan_ff <= {1'b0, start_rd_ff};
                  state_ff <= S_UNIT;
               end
            end
            S_UNIT: begin
               // Store read issued for scan_ff.
               scan_ff <= scan_ff + 1'b1;
               state_ff <= S_AWAIT;
            end
            S_AWAIT: begin
               lit_ff <= lit_rd_ff;
               state_ff <= S_AEVAL;
            end
            S_AEVAL: begin
               if (lit_ff == '0) begin
                  if (open_cnt_ff == 2'd0) begin
                     st_ff <= ST_VERIFIED;
                     phase_ff <= PH_DONE;
                     if (empty_lemma_ff) refuted_ff <= 1'b1;
                  end else if (open_cnt_ff == 2'd2) begin
                     st_ff <= ST_INVALID;
                     phase_ff <= PH_DONE;
                  end else if (var_ok(unit_ff)) begin
                     asg_we_ff <= 1'b1;
                     asg_wa_ff <= var_index(unit_ff);
                     asg_wd_ff <= unit_ff[LitW-1] ? 2'd2 : 2'd1;
                  end
                  state_ff <= S_OUT;
               end else begin
                  if (!var_ok(lit_ff) ||
                      asg_rd_ff != (lit_ff[LitW-1] ? 2'd1 : 2'd2)) begin
                     if (open_cnt_ff != 2'd2) open_cnt_ff <= open_cnt_ff + 1'b1;
                     unit_ff <= lit_ff;
                  end
                  state_ff <= S_UNIT;
               end
            end
            S_OUT: begin
               out_valid_ff <= 1'b1;
               out_st_ff <= st_ff;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) open_ff <= wp_ff)
      else $error("open clause start past write pointer");
   assert property (@(posedge clock) disable iff (reset)
      take |-> !out_valid_ff)
      else $error("item taken with result pending");
   assert property (@(posedge clock) disable iff (reset)
      $rose(refuted_ff) |-> state_ff == S_OUT)
      else $error("refutation set outside a verification");

endmodule

FILE: design/lrat_unit_propagation_checker_core.sv
// LRAT unit propagation checker, top level: item queue plus execution engine.
// Depends on lupc_pkg, lupc_front and lupc_back.
// One item at a time: a literal, an id binding or a skipped hint is finished before the next.
// The first item of a lemma adds a wipe of the assignment; the next item waits for the pop.
// A hint reads its clause start, then scans the clause, one stored literal per step.
// After reset a clearing pass over the clause table runs before the first item is taken.
module lrat_unit_propagation_checker_core
   import lupc_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic push,
   output logic full,
   input logic [1:0] req_action,
   input logic signed [12:0] req_literal,
   input logic [13:0] req_clause_id,
   output logic empty,
   input logic pop,
   output logic [2:0] rsp_status,
   output logic rsp_refuted
);

   item_type push_item, head_item;
   logic has_item, take;

   always_comb begin
      push_item.action = req_action;
      push_item.literal = req_literal;
      push_item.clause_id = req_clause_id;
   end

   lupc_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .push_item(push_item), .has_item(has_item), .head_item(head_item),
      .take(take)
   );

   lupc_back u_back (
      .clock(clock), .reset(reset), .has_item(has_item), .head_item(head_item),
      .take(take), .rsp_empty(empty), .rsp_status(rsp_status),
      .rsp_refuted(rsp_refuted), .rsp_pop(pop)
   );

endmodule
